[sv/mzuf_pkg.sv]
// ----------------------------------------------------------------------------
// mzuf_pkg: shared types and constants for the maze wall opener
// Field widths, controller states, datapath operations and status bundle.
// ----------------------------------------------------------------------------
package mzuf_pkg;

    localparam int MAX_SIDE_DEF = 32;

    localparam int ROW_W       = 5;
    localparam int COL_W       = 5;
    localparam int SIDE_W      = 6;
    localparam int OUTC_W      = 2;
    localparam int SETS_W      = 11;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(5);

    typedef enum logic [OUTC_W-1:0] {
        OUTC_BOUNDARY  = 2'd0,
        OUTC_CONNECTED = 2'd1,
        OUTC_MERGED    = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEEK1,
        ST_WALK1,
        ST_WALK2,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CLEAR,
        OP_LOAD,
        OP_SEEK1,
        OP_FOLLOW,
        OP_SEEK2,
        OP_CLOSE,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        logic clear_last;   // clearing sweep at last entry
        logic item_ok;      // offered item names an interior wall
        logic link_zero;    // registered parent read is a root mark
    } dp_status_t;

endpackage

[sv/mzuf_dpath.sv]
// ----------------------------------------------------------------------------
// mzuf_dpath: parent memory, root walker and set counters
// Executes one operation per cycle as issued by the controller.
// ----------------------------------------------------------------------------
module mzuf_dpath #(
    parameter int MAX_SIDE = mzuf_pkg::MAX_SIDE_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mzuf_pkg::SIDE_W-1:0]         cfg_wdata,
    input  logic [mzuf_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                s_tuser,
    input  mzuf_pkg::dp_op_t                    op,
    output mzuf_pkg::dp_status_t                status,
    output logic [mzuf_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import mzuf_pkg::*;

    localparam int CELLS  = MAX_SIDE * MAX_SIDE;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int LINK_W = $clog2(CELLS + 1);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int SEL_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

    // parent store: 0 = root, else parent index + 1
    logic [LINK_W-1:0] mem [CELLS];

    logic [SIDE_W-1:0] side_reg;
    logic [IDX_W-1:0]  clr_reg;
    logic [IDX_W-1:0]  cell_reg;
    logic [IDX_W-1:0]  other_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  root1_reg;
    logic [LINK_W-1:0] rd_data_reg;
    outcome_t          outcome_reg;
    outcome_t          outcome_out_reg;
    logic [SETS_W-1:0] sets_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg [MAX_SIDE];

    logic [6:0]        side_act;
    logic [ROW_W-1:0]  row_in;
    logic [COL_W-1:0]  col_in;
    logic              row_ok;
    logic              col_ok;
    logic [11:0]       cell_full;
    logic [11:0]       other_full;
    logic [IDX_W-1:0]  follow_addr;
    logic              roots_differ;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [LINK_W-1:0] wr_data;
    logic [13:0]       sq_full;
    logic [CNT_W-1:0]  sets_full;

    // side clamp and item decode
    always_comb
    begin
        side_act = ({1'b0, side_reg} > 7'(MAX_SIDE)) ? 7'(MAX_SIDE) : {1'b0, side_reg};
        row_in   = s_tdata[ROW_W-1:0];
        col_in   = s_tdata[ROW_W+COL_W-1:ROW_W];
        row_ok   = s_tuser ? (7'(row_in) + 7'd1 < side_act) : (7'(row_in) < side_act);
        col_ok   = s_tuser ? (7'(col_in) < side_act) : (7'(col_in) + 7'd1 < side_act);
        cell_full  = 12'(row_in) * 12'(side_act) + 12'(col_in);
        other_full = s_tuser ? cell_full + 12'(side_act) : cell_full + 12'd1;
    end

    assign follow_addr  = IDX_W'(rd_data_reg - LINK_W'(1));
    assign roots_differ = (cur_reg != root1_reg);

    // memory port control
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = cell_reg;
        wr_en   = 1'b0;
        wr_addr = cur_reg;
        wr_data = LINK_W'(root1_reg) + LINK_W'(1);
        unique case (op)
            OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            OP_SEEK1:
            begin
                rd_en   = 1'b1;
                rd_addr = cell_reg;
            end
            OP_FOLLOW:
            begin
                rd_en   = 1'b1;
                rd_addr = follow_addr;
            end
            OP_SEEK2:
            begin
                rd_en   = 1'b1;
                rd_addr = other_reg;
            end
            OP_CLOSE:
            begin
                wr_en = roots_differ;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // sets = cells of the grid minus linked cells inside it
    always_comb
    begin
        sq_full = 14'(side_act) * 14'(side_act);
        if (side_act == 7'd0)
        begin
            sets_full = '0;
        end
        else
        begin
            sets_full = CNT_W'(sq_full) - cnt_reg[SEL_W'(side_act - 7'd1)];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= SIDE_RESET;
            clr_reg  <= '0;
            for (int k = 0; k < MAX_SIDE; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                side_reg <= cfg_wdata;
            end
            if (op == OP_CLEAR)
            begin
                clr_reg <= clr_reg + IDX_W'(1);
            end
            // cnt_reg[k]: non-root cells below index (k+1)^2
            if (op == OP_CLOSE && roots_differ)
            begin
                for (int k = 0; k < MAX_SIDE; k++)
                begin
                    if (CNT_W'(cur_reg) < CNT_W'((k + 1) * (k + 1)))
                    begin
                        cnt_reg[k] <= cnt_reg[k] + CNT_W'(1);
                    end
                end
            end
        end
    end

    // walker and result payload
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                cell_reg    <= IDX_W'(cell_full);
                other_reg   <= IDX_W'(other_full);
                outcome_reg <= OUTC_BOUNDARY;
            end
            OP_SEEK1:
            begin
                cur_reg <= cell_reg;
            end
            OP_FOLLOW:
            begin
                cur_reg <= follow_addr;
            end
            OP_SEEK2:
            begin
                root1_reg <= cur_reg;
                cur_reg   <= other_reg;
            end
            OP_CLOSE:
            begin
                outcome_reg <= roots_differ ? OUTC_MERGED : OUTC_CONNECTED;
            end
            OP_EMIT:
            begin
                // result payload holds while the next item is worked on
                outcome_out_reg <= outcome_reg;
                sets_reg        <= SETS_W'(sets_full);
                done_reg        <= (sets_full == CNT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    assign status.clear_last = (clr_reg == IDX_W'(CELLS - 1));
    assign status.item_ok    = row_ok && col_ok;
    assign status.link_zero  = (rd_data_reg == '0);

    assign m_tdata = {(OUT_TDATA_W - OUTC_W - SETS_W - 1)'(0), done_reg, sets_reg,
                      outcome_out_reg};

endmodule

[sv/mzuf_ctrl.sv]
// ----------------------------------------------------------------------------
// mzuf_ctrl: sequencer for clearing, root walks, linking and result handoff
// Issues one datapath operation per cycle and owns both handshakes.
// ----------------------------------------------------------------------------
module mzuf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  mzuf_pkg::dp_status_t  status,
    output mzuf_pkg::dp_op_t      op
);
    import mzuf_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_tvalid_reg;
    logic   m_tvalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op            = OP_NOP;
        s_tready      = 1'b0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = status.item_ok ? ST_SEEK1 : ST_FINISH;
                end
            end
            ST_SEEK1:
            begin
                op         = OP_SEEK1;
                state_next = ST_WALK1;
            end
            ST_WALK1:
            begin
                if (status.link_zero)
                begin
                    op         = OP_SEEK2;
                    state_next = ST_WALK2;
                end
                else
                begin
                    op = OP_FOLLOW;
                end
            end
            ST_WALK2:
            begin
                if (status.link_zero)
                begin
                    op         = OP_CLOSE;
                    state_next = ST_FINISH;
                end
                else
                begin
                    op = OP_FOLLOW;
                end
            end
            ST_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    op            = OP_EMIT;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

endmodule

[sv/maze_union_find_wall_opener.sv]
// ----------------------------------------------------------------------------
// maze_union_find_wall_opener: one maze wall per transfer over a union-find
// Opens walls between disjoint cell sets and reports the sets that remain.
// ----------------------------------------------------------------------------
// Each input transfer names a cell (row, column) and its right or bottom wall.
// Walls on the grid edge or cells outside the grid report outcome 0 and change
// nothing. Otherwise both cells are followed to their roots through the parent
// memory; distinct roots are linked (neighbor's root under the chosen cell's
// root) and outcome 2 is reported, equal roots give outcome 1. Every result
// carries the number of sets left in the current grid and a done flag.
// Sequence: after reset all MAX_SIDE*MAX_SIDE parent memory entries (1024 by
// default) are cleared with s_tready low; grid_side writes are taken then too.
// A flagged item then takes a load and an emit step; any other item takes a
// load, a root walk from each cell (each link costs one read on the single
// parent memory port), a close that links the roots, and an emit.
// One item is in flight at a time; the result sits in an output register so a
// stalled sink delays only the next item's completion.
// grid_side above MAX_SIDE acts as MAX_SIDE; zero flags every item and
// reports zero sets.
// ----------------------------------------------------------------------------
module maze_union_find_wall_opener #(
    parameter int MAX_SIDE = mzuf_pkg::MAX_SIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration: grid_side
    input  logic                               cfg_we,
    input  logic [mzuf_pkg::SIDE_W-1:0]        cfg_wdata,
    // wall requests
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [mzuf_pkg::IN_TDATA_W-1:0]    s_tdata,   // [4:0] row, [9:5] column
    input  logic                               s_tuser,   // direction: 0 right, 1 bottom
    // results
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [mzuf_pkg::OUT_TDATA_W-1:0]   m_tdata    // [1:0] outcome,
                                                          // [12:2] sets_left,
                                                          // [13] maze_done
);
    import mzuf_pkg::*;

    dp_op_t     op;
    dp_status_t status;

    // sequencer: owns both handshakes
    mzuf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .op       (op)
    );

    // parent memory, walker, set counters, result register
    mzuf_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .op        (op),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule
